// ===== hdl/rfb_pkg.sv =====
// shared types and constants for the ring frame builder
// no dependencies
package rfb_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned NumPh = 9;
  localparam int unsigned PhW   = $clog2(NumPh);

  localparam logic [ByteW-1:0] StartDelim  = 8'h7E;
  localparam logic [ByteW-1:0] AccessCtrl  = 8'h10;
  localparam logic [ByteW-1:0] FrameCtrl   = 8'h00;
  localparam logic [ByteW-1:0] EndDelim    = 8'h7E;
  localparam logic [ByteW-1:0] FrameStatus = 8'h00;

  // byte positions inside one item's expansion
  localparam logic [PhW-1:0] PhStart  = 4'd0;
  localparam logic [PhW-1:0] PhAccess = 4'd1;
  localparam logic [PhW-1:0] PhFctrl  = 4'd2;
  localparam logic [PhW-1:0] PhDest   = 4'd3;
  localparam logic [PhW-1:0] PhSrc    = 4'd4;
  localparam logic [PhW-1:0] PhPay    = 4'd5;
  localparam logic [PhW-1:0] PhCheck  = 4'd6;
  localparam logic [PhW-1:0] PhEnd    = 4'd7;
  localparam logic [PhW-1:0] PhStatus = 4'd8;

  typedef struct packed {
    logic [ByteW-1:0] payload;
    logic             present;
    logic [ByteW-1:0] dest;
    logic [ByteW-1:0] src;
    logic             last;
  } item_t;

  // held item as seen by the sequencer
  typedef struct packed {
    logic  valid;
    item_t item;
  } hold_t;

endpackage

// ===== hdl/rfb_item_reg.sv =====
// input register of the ring frame builder: holds one item until it is expanded
// depends on rfb_pkg
module rfb_item_reg import rfb_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  item_t item_i,
  input  logic  item_done_i,
  output hold_t hold_o
);

  logic  valid_q, valid_d;
  item_t item_q;
  logic  accept;

  // a finishing item frees the register in the same cycle
  assign in_stall_o = valid_q && !item_done_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (item_done_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

  assign hold_o.valid = valid_q;
  assign hold_o.item  = item_q;

endmodule

// ===== hdl/rfb_seq.sv =====
// byte sequencer of the ring frame builder: picks the next frame byte of the
// held item, keeps frame state and the running xor, drives the result register
// depends on rfb_pkg
module rfb_seq import rfb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  hold_t            hold_i,
  output logic             item_done_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [ByteW-1:0] out_byte_o,
  output logic             frame_done_o,
  output logic             run_last_o
);

  logic             in_frame_q, in_frame_d;
  logic [ByteW-1:0] xor_q, xor_d;
  logic [PhW-1:0]   ph_q, ph_d;
  logic             out_valid_q, out_valid_d;
  logic [ByteW-1:0] out_byte_q;
  logic             frame_done_q;
  logic             run_last_q;

  logic [NumPh-1:0] act;
  logic             has_cur;
  logic [PhW-1:0]   cur;
  logic             more;
  logic [ByteW-1:0] cur_byte;
  logic             out_free;
  logic             fire;

  // which positions this item produces
  always_comb begin
    act                  = '0;
    act[PhSrc:PhStart]   = {5{!in_frame_q}};
    act[PhPay]           = hold_i.item.present;
    act[PhStatus:PhCheck] = {3{hold_i.item.last}};
  end

  // first active position at or after ph_q, and whether another follows
  always_comb begin
    has_cur = 1'b0;
    cur     = '0;
    more    = 1'b0;
    for (int p = NumPh - 1; p >= 0; p--) begin
      if (act[p] && (PhW'(p) >= ph_q)) begin
        has_cur = 1'b1;
        cur     = PhW'(p);
      end
    end
    for (int p = 0; p < NumPh; p++) begin
      if (act[p] && (PhW'(p) > cur)) begin
        more = 1'b1;
      end
    end
  end

  always_comb begin
    case (cur)
      PhStart:  cur_byte = StartDelim;
      PhAccess: cur_byte = AccessCtrl;
      PhFctrl:  cur_byte = FrameCtrl;
      PhDest:   cur_byte = hold_i.item.dest;
      PhSrc:    cur_byte = hold_i.item.src;
      PhPay:    cur_byte = hold_i.item.payload;
      PhCheck:  cur_byte = xor_q;
      PhEnd:    cur_byte = EndDelim;
      PhStatus: cur_byte = FrameStatus;
      default:  cur_byte = FrameStatus;
    endcase
  end

  assign out_free    = !out_valid_q || !out_stall_i;
  assign fire        = hold_i.valid && has_cur && out_free;
  // an item with nothing to send finishes at once
  assign item_done_o = hold_i.valid && (!has_cur || (out_free && !more));

  always_comb begin
    in_frame_d  = in_frame_q;
    xor_d       = xor_q;
    ph_d        = ph_q;
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = fire;
    end
    if (fire) begin
      if (cur <= PhPay) begin
        xor_d = xor_q ^ cur_byte;
      end else if (cur == PhStatus) begin
        xor_d = '0;
      end
      ph_d = cur + PhW'(1);
    end
    if (item_done_o) begin
      ph_d       = '0;
      in_frame_d = !hold_i.item.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q  <= 1'b0;
      xor_q       <= '0;
      ph_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      in_frame_q  <= in_frame_d;
      xor_q       <= xor_d;
      ph_q        <= ph_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_byte_q   <= cur_byte;
      frame_done_q <= (cur == PhStatus);
      run_last_q   <= !more;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign frame_done_o = frame_done_q;
  assign run_last_o   = run_last_q;

endmodule

// ===== hdl/ring_frame_builder_xor_fcs_core.sv =====
// ring frame builder with xor check byte: one frame byte leaves per cycle while the
// receiver does not stall; an accepted item waits in the item register, and each
// result byte is registered in the byte sequencer; throughput: 1 item per cycle
// mid-frame while not stalled, up to 9 result bytes per item; set by the byte sequencer
// reset: asynchronous, clears frame state, running xor and all valid flags
// depends on rfb_pkg, rfb_item_reg, rfb_seq
module ring_frame_builder_xor_fcs_core import rfb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ByteW-1:0] payload_byte_i,
  input  logic             byte_present_i,
  input  logic [ByteW-1:0] dest_addr_i,
  input  logic [ByteW-1:0] src_addr_i,
  input  logic             frame_last_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [ByteW-1:0] out_byte_o,
  output logic             frame_done_o,
  output logic             run_last_o
);

  item_t item;
  hold_t hold;
  logic  item_done;

  assign item.payload = payload_byte_i;
  assign item.present = byte_present_i;
  assign item.dest    = dest_addr_i;
  assign item.src     = src_addr_i;
  assign item.last    = frame_last_i;

  rfb_item_reg u_item_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .item_i      (item),
    .item_done_i (item_done),
    .hold_o      (hold)
  );

  rfb_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .hold_i       (hold),
    .item_done_o  (item_done),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .frame_done_o (frame_done_o),
    .run_last_o   (run_last_o)
  );

endmodule

// ===== test/tb_ring_frame_builder_xor_fcs_core.sv =====
// testbench for ring_frame_builder_xor_fcs_core: drives payload items, predicts every frame byte
// (header, payload, xor check byte, trailer) and compares the output stream byte by byte
// depends on rfb_pkg and the ring_frame_builder_xor_fcs_core rtl
module tb_ring_frame_builder_xor_fcs_core import rfb_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 20;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             done;
    logic             run_last;
  } frame_byte_t;

  typedef enum int {StallNone, StallLight, StallHeavy, StallPeriodic} stall_mode_e;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [ByteW-1:0] payload_byte_i;
  logic             byte_present_i;
  logic [ByteW-1:0] dest_addr_i;
  logic [ByteW-1:0] src_addr_i;
  logic             frame_last_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [ByteW-1:0] out_byte_o;
  logic             frame_done_o;
  logic             run_last_o;

  // predictor state
  logic             frame_open;
  logic [ByteW-1:0] fcs_xor;
  frame_byte_t      frame_bytes_q[$];

  int unsigned err_cnt;
  int unsigned cycle_cnt;
  int unsigned items_sent;
  int unsigned bytes_checked;
  int unsigned frames_closed;
  int unsigned burst_left;
  bit          gaps_on;
  int unsigned hold_len;

  ring_frame_builder_xor_fcs_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .payload_byte_i (payload_byte_i),
    .byte_present_i (byte_present_i),
    .dest_addr_i    (dest_addr_i),
    .src_addr_i     (src_addr_i),
    .frame_last_i   (frame_last_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .frame_done_o   (frame_done_o),
    .run_last_o     (run_last_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles, %0d frame bytes still pending",
               cycle_cnt, frame_bytes_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // expected frame bytes caused by one accepted item
  function automatic void build_frame_bytes(input item_t it);
    frame_byte_t      run[$];
    logic [ByteW-1:0] hdr[5];
    hdr = '{StartDelim, AccessCtrl, FrameCtrl, it.dest, it.src};
    if (!frame_open) begin
      frame_open = 1'b1;
      fcs_xor    = '0;
      foreach (hdr[k]) begin
        fcs_xor ^= hdr[k];
        run.push_back('{data: hdr[k], done: 1'b0, run_last: 1'b0});
      end
    end
    if (it.present) begin
      fcs_xor ^= it.payload;
      run.push_back('{data: it.payload, done: 1'b0, run_last: 1'b0});
    end
    if (it.last) begin
      run.push_back('{data: fcs_xor, done: 1'b0, run_last: 1'b0});
      run.push_back('{data: EndDelim, done: 1'b0, run_last: 1'b0});
      run.push_back('{data: FrameStatus, done: 1'b1, run_last: 1'b0});
      frame_open = 1'b0;
      fcs_xor    = '0;
      frames_closed++;
    end
    if (run.size() > 0) begin
      run[run.size()-1].run_last = 1'b1;
      items_sent++;
    end
    foreach (run[k]) frame_bytes_q.push_back(run[k]);
  endfunction

  task automatic send_item(input item_t it);
    @(negedge clk_i);
    if (gaps_on && burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = $urandom_range(1, 10);
    end
    in_valid_i     <= 1'b1;
    payload_byte_i <= it.payload;
    byte_present_i <= it.present;
    dest_addr_i    <= it.dest;
    src_addr_i     <= it.src;
    frame_last_i   <= it.last;
    do @(posedge clk_i); while (in_stall_o);
    build_frame_bytes(it);
    if (burst_left > 0) burst_left--;
  endtask

  function automatic item_t make_item(input logic [ByteW-1:0] payload, input logic present,
                                      input logic [ByteW-1:0] dest, input logic [ByteW-1:0] src,
                                      input logic last);
    item_t it;
    it.payload = payload;
    it.present = present;
    it.dest    = dest;
    it.src     = src;
    it.last    = last;
    return it;
  endfunction

  function automatic item_t rand_item(input logic present, input logic last);
    return make_item(ByteW'($urandom), present, ByteW'($urandom), ByteW'($urandom), last);
  endfunction

  // one random frame: present bytes mostly, an occasional empty item
  task automatic send_rand_frame(input int unsigned len);
    for (int unsigned k = 1; k <= len; k++) begin
      send_item(rand_item($urandom_range(0, 7) != 0, k == len));
    end
  endtask

  // receiver: changes its stall pattern now and then, long hold-off on request
  initial begin
    int unsigned hold_left;
    int unsigned mode_left;
    stall_mode_e mode;
    out_stall_i = 1'b0;
    hold_left   = 0;
    mode_left   = 0;
    mode        = StallNone;
    forever begin
      @(negedge clk_i);
      if (hold_len > 0) begin
        hold_left = hold_len;
        hold_len  = 0;
      end
      if (mode_left == 0) begin
        mode      = stall_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 80);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        case (mode)
          StallNone:  out_stall_i <= 1'b0;
          StallLight: out_stall_i <= ($urandom_range(0, 3) == 0);
          StallHeavy: out_stall_i <= ($urandom_range(0, 3) != 0);
          default:    out_stall_i <= (mode_left % 3 == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : check_bytes
    frame_byte_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (frame_bytes_q.size() == 0) begin
        $error("unexpected frame byte %02h (done %0b, run_last %0b)",
               out_byte_o, frame_done_o, run_last_o);
        err_cnt++;
      end else begin
        want = frame_bytes_q.pop_front();
        bytes_checked++;
        if (out_byte_o !== want.data) begin
          $error("out_byte: expected %02h, got %02h", want.data, out_byte_o);
          err_cnt++;
        end
        if (frame_done_o !== want.done) begin
          $error("frame_done: expected %0b, got %0b", want.done, frame_done_o);
          err_cnt++;
        end
        if (run_last_o !== want.run_last) begin
          $error("run_last: expected %0b, got %0b", want.run_last, run_last_o);
          err_cnt++;
        end
      end
    end
  end

  task automatic test_extreme_frame();
    send_item(make_item(8'h00, 1'b1, 8'hFF, 8'h00, 1'b0));
    send_item(make_item(8'hFF, 1'b1, 8'h00, 8'hFF, 1'b0));
    send_item(make_item(8'hA5, 1'b1, 8'h5A, 8'hA5, 1'b0));
    send_item(make_item(8'h5A, 1'b1, 8'hA5, 8'h5A, 1'b1));
  endtask

  // header and trailer only, no payload byte at all
  task automatic test_empty_payload();
    send_item(make_item(8'hFF, 1'b0, 8'h00, 8'hFF, 1'b1));
    send_item(make_item(8'h00, 1'b0, 8'hFF, 8'h00, 1'b1));
  endtask

  task automatic test_single_byte_frame();
    send_item(make_item(8'h7E, 1'b1, 8'h10, 8'h7E, 1'b1));
    send_item(make_item(8'hFF, 1'b1, 8'hFF, 8'hFF, 1'b1));
  endtask

  // empty items inside a frame, addresses changing mid-frame, trailer from an empty item
  task automatic test_mid_frame_items();
    send_item(make_item(8'h3C, 1'b0, 8'h12, 8'h34, 1'b0));
    send_item(make_item(8'hC3, 1'b0, 8'hFF, 8'hFF, 1'b0));
    send_item(make_item(8'h81, 1'b1, 8'h00, 8'h00, 1'b0));
    send_item(make_item(8'h18, 1'b0, 8'hAA, 8'h55, 1'b0));
    send_item(make_item(8'h42, 1'b1, 8'h55, 8'hAA, 1'b0));
    send_item(make_item(8'h99, 1'b0, 8'h66, 8'h77, 1'b1));
  endtask

  task automatic test_random_frames(input int unsigned n_items);
    int unsigned start;
    start = items_sent;
    while (items_sent - start < n_items) begin
      gaps_on = ($urandom_range(0, 9) < 7);
      if ($urandom_range(0, 9) == 0) begin
        // unstructured items
        repeat ($urandom_range(1, 6)) begin
          send_item(rand_item(1'($urandom_range(0, 1)), $urandom_range(0, 2) == 0));
        end
      end else begin
        send_rand_frame($urandom_range(1, 12));
      end
    end
    gaps_on = 1'b1;
  endtask

  // long receiver hold-off while items keep coming back to back
  task automatic test_output_hold();
    gaps_on  = 1'b0;
    hold_len = 400;
    repeat (4) send_rand_frame($urandom_range(3, 10));
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    payload_byte_i = '0;
    byte_present_i = 1'b0;
    dest_addr_i    = '0;
    src_addr_i     = '0;
    frame_last_i   = 1'b0;
    frame_open     = 1'b0;
    fcs_xor        = '0;
    err_cnt        = 0;
    cycle_cnt      = 0;
    items_sent     = 0;
    bytes_checked  = 0;
    frames_closed  = 0;
    burst_left     = 0;
    gaps_on        = 1'b1;
    hold_len       = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_extreme_frame();
    test_empty_payload();
    test_single_byte_frame();
    test_mid_frame_items();
    test_output_hold();
    test_random_frames(100);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (frame_bytes_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d byte-producing items, %0d frames closed, %0d frame bytes checked",
             items_sent, frames_closed, bytes_checked);
    $display("including empty payloads, empty mid-frame items and a long output hold-off");
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/rfb_pkg.sv
hdl/rfb_item_reg.sv
hdl/rfb_seq.sv
hdl/ring_frame_builder_xor_fcs_core.sv
test/tb_ring_frame_builder_xor_fcs_core.sv
